// ===== sv/touch_event_queue_with_recovery_assert.svh =====
// Assertion macros for the touch event queue.
`ifndef TOUCH_EVENT_QUEUE_WITH_RECOVERY_ASSERT_SVH
`define TOUCH_EVENT_QUEUE_WITH_RECOVERY_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TEQ_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
// Implication checked with the consequent in the cycle after the antecedent.
`define TEQ_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

// ===== sv/teq_pkg.sv =====
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and constants of the touch event queue.
// ----------------------------------------------------------------------------
package teq_pkg;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIMEOUT_LIMIT_DEF = 3;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_SUPPRESS = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_TIMEOUT = 3'd1;
  localparam logic [2:0] ST_BADSTATE = 3'd3;
  localparam logic [2:0] ST_NOMEM = 3'd4;
  localparam logic [2:0] ST_OTHER = 3'd5;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_MOVE = 2'd2;
  localparam logic [1:0] EV_UP = 2'd3;

  typedef struct packed {
    logic [1:0]  event_code;
    logic        pressed;
    logic        interrupted;
    logic        pos_valid;
    logic [15:0] x;
    logic [15:0] y;
    logic [3:0]  fingers;
  } touch_t;

  typedef enum logic [1:0] {S_IDLE, S_EXEC} state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;
endpackage

// ===== sv/teq_ctrl.sv =====
// ----------------------------------------------------------------------------
// teq_ctrl
// Sequencer: captures an item, lets the datapath execute it, holds a result.
// ----------------------------------------------------------------------------
module teq_ctrl
  import teq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic is_read,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);
  state_t state, state_next;
  logic out_pend, out_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_pend <= 1'b0;
    end else begin
      state <= state_next;
      out_pend <= out_pend_next;
    end
  end

  assign out_valid = out_pend;

  always_comb begin
    state_next = state;
    out_pend_next = out_pend && !out_ready;
    in_ready = 1'b0;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = !out_pend || out_ready;
        if (in_valid && (!out_pend || out_ready)) begin
          cmd.load = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = S_IDLE;
        if (is_read) out_pend_next = 1'b1;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `include "touch_event_queue_with_recovery_assert.svh"
  `TEQ_ASSERT_IMP(a_no_load_while_full, out_valid && !out_ready, !cmd.load)
  `TEQ_ASSERT_NEXT(a_load_exec, cmd.load, cmd.exec)
  `TEQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
endmodule

// ===== sv/teq_dp.sv =====
// ----------------------------------------------------------------------------
// teq_dp
// Datapath: event ring, flags, status and result register.
// ----------------------------------------------------------------------------
module teq_dp
  import teq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIMEOUT_LIMIT = TIMEOUT_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output logic        is_read,
  input  logic [1:0]  opcode,
  input  logic [2:0]  in_error,
  input  touch_t      in_touch,
  input  logic [31:0] in_time,
  output logic [2:0]  res_status,
  output touch_t      res_touch,
  output logic [31:0] res_time
);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [2:0] TL = 3'(TIMEOUT_LIMIT);

  touch_t      qt [QUEUE_DEPTH];
  logic [31:0] qtm [QUEUE_DEPTH];

  logic [1:0]  op;
  logic [2:0]  err;
  touch_t      s_in;
  logic [31:0] t_in;
  touch_t      tail_rd, head_rd;
  logic [31:0] head_tm;

  logic [IW-1:0] head_index, head_index_next;
  logic [CW-1:0] entry_count, entry_count_next;
  logic [31:0] lost_total, lost_total_next, latest_time, latest_time_next;
  touch_t latest_touch, latest_touch_next;
  logic [2:0] last_status, last_status_next, timeout_run, timeout_run_next;
  logic [31:0] suppress_time, suppress_time_next;
  logic f_wait, f_sv, f_ovf, f_rv, f_rp, f_int, f_sup, f_rec, f_to;
  logic n_wait, n_sv, n_ovf, n_rv, n_rp, n_int, n_sup, n_rec, n_to;
  logic wr_en;
  logic [IW-1:0] wr_addr;
  touch_t wr_touch;
  logic [2:0] st_next;
  touch_t o_next;
  logic [31:0] ot_next;
  logic [IW-1:0] tail_addr, app_addr;

  assign is_read = (op == OP_READ);

  function automatic logic [IW-1:0] wrap(input logic [CW:0] v);
    logic [CW:0] r;
    r = v;
    if (r >= (CW+1)'(QUEUE_DEPTH)) r = r - (CW+1)'(QUEUE_DEPTH);
    return r[IW-1:0];
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [CW:0] b);
    logic [32:0] s;
    s = {1'b0, a} + 33'(b);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  assign tail_addr = wrap((CW+1)'(head_index) + (CW+1)'(entry_count) - (CW+1)'(1));
  assign app_addr = wrap((CW+1)'(head_index) + (CW+1)'(entry_count));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= opcode;
      err <= (in_error > ST_OTHER) ? ST_OTHER : in_error;
      s_in <= in_touch;
      t_in <= in_time;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      qt[wr_addr] <= wr_touch;
      qtm[wr_addr] <= t_in;
    end
    tail_rd <= qt[wrap((CW+1)'(head_index) + (CW+1)'(entry_count) - (CW+1)'(1))];
    head_rd <= qt[head_index];
    head_tm <= qtm[head_index];
  end

  always_comb begin
    logic mask, bgn;
    touch_t s;
    head_index_next = head_index;
    entry_count_next = entry_count;
    lost_total_next = lost_total;
    latest_time_next = latest_time;
    latest_touch_next = latest_touch;
    last_status_next = last_status;
    timeout_run_next = timeout_run;
    suppress_time_next = suppress_time;
    {n_wait, n_sv, n_ovf, n_rv, n_rp, n_int, n_sup, n_rec, n_to} =
      {f_wait, f_sv, f_ovf, f_rv, f_rp, f_int, f_sup, f_rec, f_to};
    wr_en = 1'b0;
    wr_addr = app_addr;
    s = s_in;
    wr_touch = s;
    st_next = ST_OK;
    o_next = '0;
    ot_next = '0;
    mask = 1'b0;
    bgn = 1'b0;
    if (cmd.exec) begin
      if ((op == OP_PUSH || op == OP_SUPPRESS) && err != ST_OK) begin
        mask = (err == ST_TIMEOUT) && (timeout_run < TL);
        lost_total_next = sat_add(lost_total, (CW+1)'(entry_count));
        head_index_next = '0;
        entry_count_next = '0;
        n_sv = 1'b0;
        last_status_next = err;
        if (mask) begin
          timeout_run_next = timeout_run + 3'd1;
          bgn = !f_rec && f_rv && f_rp;
          if (bgn) begin
            n_rec = 1'b1;
            n_int = 1'b1;
          end
          n_wait = !n_rec;
        end else begin
          timeout_run_next = (err == ST_TIMEOUT) ? TL + 3'd1 : 3'd0;
          if (err == ST_TIMEOUT) n_to = 1'b1;
          n_wait = 1'b1;
        end
        latest_touch_next = '0;
        latest_touch_next.pressed = n_rec;
        if (!mask) begin
          n_rv = 1'b0;
          n_rp = 1'b0;
          n_int = 1'b0;
          n_rec = 1'b0;
        end
      end else if (op == OP_PUSH) begin
        n_sv = 1'b1;
        last_status_next = ST_OK;
        timeout_run_next = '0;
        if (f_rec) begin
          s.interrupted = 1'b0;
          s.event_code = s.pressed ? EV_MOVE : EV_UP;
          if (!s.pressed) begin
            s.pos_valid = 1'b0;
            s.x = '0;
            s.y = '0;
            s.fingers = '0;
          end
          n_rec = 1'b0;
          n_wait = 1'b0;
        end
        wr_touch = s;
        if (n_wait) begin
          latest_touch_next = '0;
          latest_time_next = t_in;
          if (!s.pressed) n_wait = 1'b0;
        end else begin
          latest_touch_next = s;
          latest_time_next = t_in;
          if (s.event_code == EV_NONE) begin
          end else if (s.event_code == EV_MOVE && entry_count != '0
                       && tail_rd.event_code == EV_MOVE) begin
            wr_en = 1'b1;
            wr_addr = tail_addr;
          end else if (entry_count >= CW'(QUEUE_DEPTH)) begin
            lost_total_next = sat_add(lost_total, (CW+1)'(entry_count) + (CW+1)'(1));
            head_index_next = '0;
            entry_count_next = '0;
            n_ovf = 1'b1;
            n_wait = 1'b1;
            latest_touch_next = '0;
          end else begin
            wr_en = 1'b1;
            entry_count_next = entry_count + CW'(1);
          end
        end
      end else if (op == OP_SUPPRESS) begin
        lost_total_next = sat_add(lost_total, (CW+1)'(entry_count));
        head_index_next = '0;
        entry_count_next = '0;
        if (!f_sup && f_rv && f_rp) begin
          n_sup = 1'b1;
          suppress_time_next = t_in;
        end
        n_sv = 1'b1;
        last_status_next = ST_OK;
        latest_touch_next = '0;
        latest_time_next = t_in;
        n_wait = s.pressed;
        n_rec = 1'b0;
        n_int = 1'b0;
        n_rv = 1'b0;
        n_rp = 1'b0;
        timeout_run_next = '0;
      end else if (op == OP_READ) begin
        if (f_to) begin
          n_to = 1'b0;
          n_rv = 1'b0;
          n_rp = 1'b0;
          st_next = ST_TIMEOUT;
        end else if (f_int) begin
          ot_next = latest_time;
          o_next.pressed = 1'b1;
          o_next.interrupted = 1'b1;
          n_int = 1'b0;
          n_rv = 1'b1;
          n_rp = 1'b1;
        end else if (last_status != ST_OK || !f_sv) begin
          if (last_status == ST_TIMEOUT && timeout_run != '0 && timeout_run <= TL) begin
            ot_next = latest_time;
            o_next.pressed = latest_touch.pressed;
            n_rv = 1'b1;
            n_rp = latest_touch.pressed;
          end else begin
            n_rv = 1'b0;
            n_rp = 1'b0;
            st_next = (last_status != ST_OK) ? last_status : ST_BADSTATE;
          end
        end else if (f_ovf) begin
          n_ovf = 1'b0;
          n_rv = 1'b0;
          n_rp = 1'b0;
          st_next = ST_NOMEM;
        end else if (f_sup) begin
          ot_next = suppress_time;
          o_next.interrupted = 1'b1;
          n_sup = 1'b0;
          n_rp = 1'b0;
          n_rv = 1'b1;
        end else begin
          if (entry_count != '0) begin
            o_next = head_rd;
            ot_next = head_tm;
            head_index_next = wrap((CW+1)'(head_index) + (CW+1)'(1));
            entry_count_next = entry_count - CW'(1);
          end else begin
            o_next = latest_touch;
            o_next.event_code = EV_NONE;
            ot_next = latest_time;
          end
          n_rv = 1'b1;
          n_rp = o_next.pressed;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index <= '0;
      entry_count <= '0;
      lost_total <= '0;
      latest_time <= '0;
      latest_touch <= '0;
      last_status <= ST_BADSTATE;
      suppress_time <= '0;
      timeout_run <= '0;
      {f_wait, f_sv, f_ovf, f_rv, f_rp, f_int, f_sup, f_rec, f_to} <= 9'b1_0000_0000;
    end else begin
      head_index <= head_index_next;
      entry_count <= entry_count_next;
      lost_total <= lost_total_next;
      latest_time <= latest_time_next;
      latest_touch <= latest_touch_next;
      last_status <= last_status_next;
      suppress_time <= suppress_time_next;
      timeout_run <= timeout_run_next;
      {f_wait, f_sv, f_ovf, f_rv, f_rp, f_int, f_sup, f_rec, f_to} <=
        {n_wait, n_sv, n_ovf, n_rv, n_rp, n_int, n_sup, n_rec, n_to};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && is_read) begin
      res_status <= st_next;
      res_touch <= o_next;
      res_time <= ot_next;
    end
  end

  `include "touch_event_queue_with_recovery_assert.svh"
  `TEQ_ASSERT_IMP(a_count_range, 1'b1, entry_count <= CW'(QUEUE_DEPTH))
  `TEQ_ASSERT_IMP(a_run_range, 1'b1, timeout_run <= TL + 3'd1)
  `TEQ_ASSERT_NEXT(a_lost_mono, 1'b1, lost_total >= $past(lost_total))
endmodule

// ===== sv/touch_event_queue_with_recovery.sv =====
// An item is captured and then executed in the cycle after; a read result
// is valid from the clock edge that ends execution and is held until taken.
// The capture and execute steps of the sequencer mean no new item is taken while one
// executes; a result still waiting to be taken holds the input back.
// Reset: synchronous; queue empty, status invalid state, release guard set.
// ----------------------------------------------------------------------------
// touch_event_queue_with_recovery
// Top level of the queued touch event buffer with error recovery.
// ----------------------------------------------------------------------------
module touch_event_queue_with_recovery
  import teq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIMEOUT_LIMIT = TIMEOUT_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [2:0]  in_error,
  input  logic [1:0]  sample_event,
  input  logic        sample_pressed,
  input  logic        sample_interrupted,
  input  logic        sample_pos_valid,
  input  logic [15:0] sample_x,
  input  logic [15:0] sample_y,
  input  logic [3:0]  sample_fingers,
  input  logic [31:0] sample_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [1:0]  out_event,
  output logic        out_pressed,
  output logic        out_interrupted,
  output logic        out_pos_valid,
  output logic [15:0] out_x,
  output logic [15:0] out_y,
  output logic [3:0]  out_fingers,
  output logic [31:0] out_time
);
  cmd_t cmd;
  logic is_read;
  touch_t in_touch, res_touch;

  assign in_touch = '{event_code: sample_event, pressed: sample_pressed,
                      interrupted: sample_interrupted, pos_valid: sample_pos_valid,
                      x: sample_x, y: sample_y, fingers: sample_fingers};

  teq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .is_read(is_read), .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
  );

  teq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .TIMEOUT_LIMIT(TIMEOUT_LIMIT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .is_read(is_read), .opcode(opcode),
    .in_error(in_error), .in_touch(in_touch), .in_time(sample_time),
    .res_status(status), .res_touch(res_touch), .res_time(out_time)
  );

  assign out_event = res_touch.event_code;
  assign out_pressed = res_touch.pressed;
  assign out_interrupted = res_touch.interrupted;
  assign out_pos_valid = res_touch.pos_valid;
  assign out_x = res_touch.x;
  assign out_y = res_touch.y;
  assign out_fingers = res_touch.fingers;
endmodule

// ===== test/tb_touch_event_queue_with_recovery.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_touch_event_queue_with_recovery
// Self-checking bench for the queued touch event buffer with error recovery.
// A directed opening drives gestures, merged moves, sampler errors, masked
// timeouts and suppression. Random gesture traffic follows, with overflow
// bursts and random gaps on both handshakes. Every read result is compared
// with a cycle-free model of the queue, the flags and the recovery logic.
// ----------------------------------------------------------------------------
module tb_touch_event_queue_with_recovery;
  import teq_pkg::*;

  localparam int DEPTH = 16;
  localparam int TMO_LIMIT = 3;
  localparam int RANDOM_ITEMS = 1250;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [1:0] EV_DOWN = 2'd1;
  localparam logic [2:0] ST_BADARG = 3'd2;
  localparam logic [2:0] ST_UNDEFINED = 3'd7;

  typedef struct {
    logic [1:0]  op;
    logic [2:0]  err;
    touch_t      smp;
    logic [31:0] stamp;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]  st;
    touch_t      tch;
    logic [31:0] stamp;
  } read_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = OP_PUSH;
  logic [2:0] in_error = ST_OK;
  logic [1:0] sample_event = EV_NONE;
  logic sample_pressed = 1'b0;
  logic sample_interrupted = 1'b0;
  logic sample_pos_valid = 1'b0;
  logic [15:0] sample_x = '0;
  logic [15:0] sample_y = '0;
  logic [3:0] sample_fingers = '0;
  logic [31:0] sample_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [1:0] out_event;
  logic out_pressed;
  logic out_interrupted;
  logic out_pos_valid;
  logic [15:0] out_x;
  logic [15:0] out_y;
  logic [3:0] out_fingers;
  logic [31:0] out_time;

  touch_event_queue_with_recovery DUT (.*);

  always #1 clk = ~clk;

  // Model state.
  touch_t      ring_touch [DEPTH];
  logic [31:0] ring_time [DEPTH];
  int unsigned head, count, tmo_run;
  touch_t      last_touch;
  logic [31:0] last_time, supp_time;
  logic [2:0]  last_st;
  bit f_wait, f_sval, f_ovf, f_rval, f_rpress, f_intr, f_supp, f_recov, f_tout;

  cmd_item_t    pending [$];
  read_result_t expected_reads [$];
  cmd_item_t    cur;
  int gap_in, stall_out, accepted, reads_seen, mismatches;
  bit calm;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void push_sample(logic [2:0] err, touch_t s, logic [31:0] t);
    bit tmo, mask;
    int unsigned tail;
    if (err != ST_OK) begin
      tmo = (err == ST_TIMEOUT);
      mask = tmo && tmo_run < TMO_LIMIT;
      head = 0;
      count = 0;
      f_sval = 0;
      last_st = err;
      if (mask) begin
        tmo_run++;
        if (!f_recov && f_rval && f_rpress) begin
          f_recov = 1;
          f_intr = 1;
        end
        f_wait = !f_recov;
      end else begin
        tmo_run = tmo ? TMO_LIMIT + 1 : 0;
        if (tmo) f_tout = 1;
        f_wait = 1;
      end
      last_touch = '0;
      last_touch.pressed = f_recov;
      if (!mask) begin
        f_rval = 0;
        f_rpress = 0;
        f_intr = 0;
        f_recov = 0;
      end
      return;
    end
    f_sval = 1;
    last_st = ST_OK;
    tmo_run = 0;
    if (f_recov) begin
      s.interrupted = 0;
      s.event_code = s.pressed ? EV_MOVE : EV_UP;
      if (!s.pressed) begin
        s.pos_valid = 0;
        s.x = '0;
        s.y = '0;
        s.fingers = '0;
      end
      f_recov = 0;
      f_wait = 0;
    end
    if (f_wait) begin
      last_touch = '0;
      last_time = t;
      if (!s.pressed) f_wait = 0;
      return;
    end
    last_touch = s;
    last_time = t;
    if (s.event_code == EV_NONE) return;
    if (s.event_code == EV_MOVE && count != 0) begin
      tail = (head + count - 1) % DEPTH;
      if (ring_touch[tail].event_code == EV_MOVE) begin
        ring_touch[tail] = s;
        ring_time[tail] = t;
        return;
      end
    end
    if (count >= DEPTH) begin
      head = 0;
      count = 0;
      f_ovf = 1;
      f_wait = 1;
      last_touch = '0;
      last_time = t;
      return;
    end
    tail = (head + count) % DEPTH;
    ring_touch[tail] = s;
    ring_time[tail] = t;
    count++;
  endfunction

  function automatic read_result_t pop_event();
    read_result_t r;
    r = '0;
    if (f_tout) begin
      f_tout = 0;
      f_rval = 0;
      f_rpress = 0;
      r.st = ST_TIMEOUT;
      return r;
    end
    if (f_intr) begin
      r.stamp = last_time;
      r.tch.pressed = 1;
      r.tch.interrupted = 1;
      f_intr = 0;
      f_rval = 1;
      f_rpress = 1;
      return r;
    end
    if (last_st != ST_OK || !f_sval) begin
      if (last_st == ST_TIMEOUT && tmo_run > 0 && tmo_run <= TMO_LIMIT) begin
        r.stamp = last_time;
        r.tch.pressed = last_touch.pressed;
        f_rval = 1;
        f_rpress = r.tch.pressed;
        return r;
      end
      f_rval = 0;
      f_rpress = 0;
      r.st = (last_st != ST_OK) ? last_st : ST_BADSTATE;
      return r;
    end
    if (f_ovf) begin
      f_ovf = 0;
      f_rval = 0;
      f_rpress = 0;
      r.st = ST_NOMEM;
      return r;
    end
    if (f_supp) begin
      r.stamp = supp_time;
      r.tch.interrupted = 1;
      f_supp = 0;
      f_rpress = 0;
      f_rval = 1;
      return r;
    end
    if (count != 0) begin
      r.tch = ring_touch[head];
      r.stamp = ring_time[head];
      head = (head + 1) % DEPTH;
      count--;
    end else begin
      r.tch = last_touch;
      r.stamp = last_time;
      r.tch.event_code = EV_NONE;
    end
    f_rval = 1;
    f_rpress = r.tch.pressed;
    return r;
  endfunction

  function automatic void apply_item(cmd_item_t it);
    logic [2:0] err;
    err = (it.err > ST_OTHER) ? ST_OTHER : it.err;
    if (it.op == OP_PUSH || (it.op == OP_SUPPRESS && err != ST_OK)) begin
      push_sample(err, it.smp, it.stamp);
    end else if (it.op == OP_SUPPRESS) begin
      head = 0;
      count = 0;
      if (!f_supp && f_rval && f_rpress) begin
        f_supp = 1;
        supp_time = it.stamp;
      end
      f_sval = 1;
      last_st = ST_OK;
      last_touch = '0;
      last_time = it.stamp;
      f_wait = it.smp.pressed;
      f_recov = 0;
      f_intr = 0;
      f_rval = 0;
      f_rpress = 0;
      tmo_run = 0;
    end else if (it.op == OP_READ) begin
      expected_reads.push_back(pop_event());
    end
  endfunction

  function automatic void add(logic [1:0] op, logic [2:0] err, logic [1:0] ev, bit pr,
                              logic [15:0] x, logic [15:0] y, logic [3:0] fg,
                              logic [31:0] t);
    cmd_item_t it;
    it.op = op;
    it.err = err;
    it.smp.event_code = ev;
    it.smp.pressed = pr;
    it.smp.interrupted = 1'($urandom_range(0, 1));
    it.smp.pos_valid = 1'($urandom_range(0, 1));
    it.smp.x = x;
    it.smp.y = y;
    it.smp.fingers = fg;
    it.stamp = t;
    pending.push_back(it);
  endfunction

  function automatic void add_random(logic [1:0] op, logic [1:0] ev, bit pr);
    logic [2:0] err;
    int r;
    r = $urandom_range(0, 99);
    err = ST_OK;
    if (r < 7) err = ST_TIMEOUT;
    else if (r < 10) err = 3'($urandom_range(2, 7));
    add(op, err, ev, pr, 16'($urandom), 16'($urandom), 4'($urandom), $urandom);
  endfunction

  // Random gestures: release, press, a run of moves, lift; reads interleaved.
  function automatic void add_gesture(int reads_pct);
    int moves;
    moves = $urandom_range(0, 25);
    add_random(OP_PUSH, EV_UP, 0);
    add_random(OP_PUSH, EV_DOWN, 1);
    for (int i = 0; i < moves; i++) begin
      if ($urandom_range(0, 99) < reads_pct)
        add_random(OP_READ, 2'($urandom), 1'($urandom));
      if ($urandom_range(0, 9) == 0) add_random(OP_PUSH, 2'($urandom), 1'($urandom));
      else add_random(OP_PUSH, EV_MOVE, 1);
    end
    if ($urandom_range(0, 9) == 0) add_random(OP_SUPPRESS, 2'($urandom), 1'($urandom));
    add_random(OP_PUSH, EV_UP, 0);
    for (int i = $urandom_range(0, 4); i > 0; i--) add_random(OP_READ, EV_NONE, 0);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_item(cur);
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_in > 0) begin
          gap_in--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          opcode <= cur.op;
          in_error <= cur.err;
          sample_event <= cur.smp.event_code;
          sample_pressed <= cur.smp.pressed;
          sample_interrupted <= cur.smp.interrupted;
          sample_pos_valid <= cur.smp.pos_valid;
          sample_x <= cur.smp.x;
          sample_y <= cur.smp.y;
          sample_fingers <= cur.smp.fingers;
          sample_time <= cur.stamp;
          in_valid <= 1'b1;
          gap_in = pick_gap();
          if ($urandom_range(0, 99) == 0) calm = !calm;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    read_result_t got, want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.st = status;
        got.tch.event_code = out_event;
        got.tch.pressed = out_pressed;
        got.tch.interrupted = out_interrupted;
        got.tch.pos_valid = out_pos_valid;
        got.tch.x = out_x;
        got.tch.y = out_y;
        got.tch.fingers = out_fingers;
        got.stamp = out_time;
        reads_seen++;
        if (expected_reads.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result: %p", got);
        end else begin
          want = expected_reads.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (stall_out > 0) begin
        stall_out--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < 20) stall_out = pick_gap();
      end
    end
  end

  initial begin
    head = 0;
    count = 0;
    tmo_run = 0;
    last_touch = '0;
    last_time = '0;
    supp_time = '0;
    last_st = ST_BADSTATE;
    {f_sval, f_ovf, f_rval, f_rpress, f_intr, f_supp, f_recov, f_tout} = '0;
    f_wait = 1;
    // Directed opening.
    add(OP_READ, ST_OK, EV_NONE, 0, 0, 0, 0, 0);
    add(OP_PUSH, ST_OK, EV_DOWN, 1, 16'h1234, 16'h5678, 4'd1, 32'd10);
    add(OP_PUSH, ST_OK, EV_UP, 0, 0, 0, 0, 32'd11);
    add(OP_READ, ST_OK, EV_NONE, 0, 0, 0, 0, 0);
    add(OP_PUSH, ST_OK, EV_DOWN, 1, 16'hFFFF, 16'h0000, 4'hF, 32'hFFFFFFFF);
    add(OP_PUSH, ST_OK, EV_MOVE, 1, 16'h0000, 16'hFFFF, 4'h0, 32'd0);
    add(OP_PUSH, ST_OK, EV_MOVE, 1, 16'h00FF, 16'hFF00, 4'h5, 32'd20);
    add(OP_PUSH, ST_OK, EV_NONE, 1, 16'h0001, 16'h0002, 4'h3, 32'd21);
    add(OP_READ, ST_OK, EV_NONE, 0, 0, 0, 0, 0);
    add(OP_READ, ST_OK, EV_NONE, 0, 0, 0, 0, 0);
    add(OP_READ, ST_OK, EV_NONE, 0, 0, 0, 0, 0);
    for (int i = 0; i < 4; i++) begin
      add(OP_PUSH, ST_TIMEOUT, EV_NONE, 0, 0, 0, 0, 32'd30 + i);
      add(OP_READ, ST_OK, EV_NONE, 0, 0, 0, 0, 0);
    end
    add(OP_PUSH, ST_UNDEFINED, EV_DOWN, 1, 0, 0, 0, 32'd40);
    add(OP_READ, ST_OK, EV_NONE, 0, 0, 0, 0, 0);
    add(OP_PUSH, ST_BADARG, EV_UP, 0, 0, 0, 0, 32'd41);
    add(OP_PUSH, ST_OK, EV_UP, 0, 0, 0, 0, 32'd42);
    add(OP_PUSH, ST_OK, EV_DOWN, 1, 16'd7, 16'd8, 4'd2, 32'd43);
    add(OP_READ, ST_OK, EV_NONE, 0, 0, 0, 0, 0);
    add(OP_SUPPRESS, ST_OK, EV_NONE, 1, 0, 0, 0, 32'd50);
    add(OP_SPARE, ST_OK, EV_NONE, 0, 0, 0, 0, 0);
    add(OP_READ, ST_OK, EV_NONE, 0, 0, 0, 0, 0);
    add(OP_READ, ST_OK, EV_NONE, 0, 0, 0, 0, 0);
    // Random part: mostly well-formed gestures, some with reads too rare to keep the
    // queue from overflowing, plus loose noise.
    while (pending.size() < RANDOM_ITEMS + 25) begin
      if ($urandom_range(0, 3) == 0) begin
        for (int i = $urandom_range(1, 6); i > 0; i--)
          add_random(2'($urandom), 2'($urandom), 1'($urandom));
      end else begin
        add_gesture($urandom_range(0, 3) == 0 ? 5 : 50);
      end
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending.size() == 0 && !in_valid);
    wait (expected_reads.size() == 0);
    repeat (20) @(posedge clk);
    $display("Ran %0d items through the buffer and checked %0d read results.",
             accepted, reads_seen);
    $display("Mismatches: %0d, results still outstanding: %0d.",
             mismatches, expected_reads.size());
    if (mismatches == 0 && expected_reads.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d items pending.", pending.size());
    $display("FAIL");
    $finish;
  end

endmodule
